// File: design/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the s-expression token lexer
// Token record layout, token kinds and the saturating counter width.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int CNT_W       = 16;
   localparam int KIND_W      = 4;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd0;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd1;
   localparam logic [KIND_W-1:0] KIND_QUOTE  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_STRING = 4'd3;
   localparam logic [KIND_W-1:0] KIND_DOT    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_BOOL   = 4'd5;
   localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd6;
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 4'd7;
   localparam logic [KIND_W-1:0] KIND_END    = 4'd8;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd9;

   typedef struct packed {
      logic [CNT_W-1:0]  column;
      logic [CNT_W-1:0]  line;
      logic [CNT_W-1:0]  length;
      logic [CNT_W-1:0]  start;
      logic [KIND_W-1:0] kind;
   } token_type;

   // tokens produced by one source byte (at most two)
   typedef struct packed {
      logic [1:0] count;
      token_type  tok1;
      token_type  tok0;
   } push_type;

   // saturating increment
   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

// File: design/stl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_core: lexer state and single-pass byte step
// Holds mode, counters and pending lexeme; turns one byte into 0..2 tokens.
// ----------------------------------------------------------------------------
module stl_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        src_byte,
   input  logic              src_end,
   output stl_pkg::push_type push
);
   import stl_pkg::*;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_SYMBOL  = 2'd1;
   localparam logic [1:0] MODE_STRING  = 2'd2;
   localparam logic [1:0] MODE_COMMENT = 2'd3;

   logic [1:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] line_ff, line_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] pstart_ff, pstart_in;
   logic [CNT_W-1:0] pline_ff, pline_in;
   logic [CNT_W-1:0] pcol_ff, pcol_in;
   logic [CNT_W-1:0] plen_ff, plen_in;
   logic [15:0]      chars_ff, chars_in;
   logic             numeric_ff, numeric_in;
   logic [1:0]       dots_ff, dots_in;
   logic             sign_ff, sign_in;
   logic             done_ff, done_in;

   // classify the pending lexeme from its current state
   function automatic logic [KIND_W-1:0] classify(
      input logic [CNT_W-1:0] len, input logic [15:0] chars,
      input logic numeric, input logic [1:0] dots, input logic sign);
      logic [KIND_W-1:0] k;
      if (len == CNT_W'(1) && chars[15:8] == ".") begin
         k = KIND_DOT;
      end else if (len == CNT_W'(2) && (chars == "#t" || chars == "#f")) begin
         k = KIND_BOOL;
      end else if (numeric && dots <= 2'd1 && !(sign && len == CNT_W'(1))) begin
         k = KIND_NUMBER;
      end else begin
         k = KIND_SYMBOL;
      end
      return k;
   endfunction

   logic      flush;
   logic      other_v;
   token_type sym_tok;
   token_type other_tok;
   logic      is_nl;
   logic      is_space;
   logic      is_delim;
   logic      is_digit;
   logic      from_idle;

   assign is_nl    = (src_byte == 8'h0A);
   assign is_space = is_nl || src_byte == 8'h20 || src_byte == 8'h09 || src_byte == 8'h0D;
   assign is_delim = is_space || src_byte == "(" || src_byte == ")" || src_byte == "\"" ||
                     src_byte == ";" || src_byte == "'";
   assign is_digit = (src_byte >= "0") && (src_byte <= "9");

   // pending lexeme as a token, classified before this byte
   always_comb begin
      sym_tok.kind   = classify(plen_ff, chars_ff, numeric_ff, dots_ff, sign_ff);
      sym_tok.start  = pstart_ff;
      sym_tok.length = plen_ff;
      sym_tok.line   = pline_ff;
      sym_tok.column = pcol_ff;
   end

   // one byte step
   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      col_in     = col_ff;
      pstart_in  = pstart_ff;
      pline_in   = pline_ff;
      pcol_in    = pcol_ff;
      plen_in    = plen_ff;
      chars_in   = chars_ff;
      numeric_in = numeric_ff;
      dots_in    = dots_ff;
      sign_in    = sign_ff;
      done_in    = done_ff;
      flush      = 1'b0;
      other_v    = 1'b0;
      other_tok  = '0;
      from_idle  = 1'b0;

      if (step && !done_ff) begin
         if (src_end) begin
            // close out the stream
            done_in = 1'b1;
            mode_in = MODE_IDLE;
            other_v = 1'b1;
            if (mode_ff == MODE_STRING) begin
               other_tok.kind   = KIND_ERROR;
               other_tok.start  = pstart_ff;
               other_tok.length = plen_ff;
               other_tok.line   = pline_ff;
               other_tok.column = pcol_ff;
            end else begin
               flush            = (mode_ff == MODE_SYMBOL);
               other_tok.kind   = KIND_END;
               other_tok.start  = pos_ff;
               other_tok.length = '0;
               other_tok.line   = line_ff;
               other_tok.column = col_ff;
            end
         end else begin
            // advance position counters
            pos_in = bump(pos_ff);
            if (is_nl) begin
               line_in = bump(line_ff);
               col_in  = '0;
            end else begin
               col_in = bump(col_ff);
            end

            unique case (mode_ff)
               MODE_COMMENT: begin
                  if (is_nl) mode_in = MODE_IDLE;
               end
               MODE_STRING: begin
                  plen_in = bump(plen_ff);
                  if (src_byte == "\"") begin
                     other_v          = 1'b1;
                     other_tok.kind   = KIND_STRING;
                     other_tok.start  = pstart_ff;
                     other_tok.length = plen_in;
                     other_tok.line   = pline_ff;
                     other_tok.column = pcol_ff;
                     mode_in          = MODE_IDLE;
                  end
               end
               MODE_SYMBOL: begin
                  if (!is_delim) begin
                     if (plen_ff == CNT_W'(1)) chars_in[7:0] = src_byte;
                     if (!is_digit && src_byte != ".") numeric_in = 1'b0;
                     if (src_byte == "." && dots_ff < 2'd2) dots_in = dots_ff + 2'd1;
                     plen_in = bump(plen_ff);
                  end else begin
                     flush     = 1'b1;
                     mode_in   = MODE_IDLE;
                     from_idle = 1'b1;
                  end
               end
               default: from_idle = 1'b1;
            endcase

            // handle the byte as the start of something
            if (from_idle) begin
               other_tok.start  = pos_ff;
               other_tok.length = CNT_W'(1);
               other_tok.line   = line_in;
               other_tok.column = col_in;
               if (is_space) begin
                  other_v = 1'b0;
               end else if (src_byte == ";") begin
                  mode_in = MODE_COMMENT;
               end else if (src_byte == "(") begin
                  other_v        = 1'b1;
                  other_tok.kind = KIND_LPAREN;
               end else if (src_byte == ")") begin
                  other_v        = 1'b1;
                  other_tok.kind = KIND_RPAREN;
               end else if (src_byte == "'") begin
                  other_v        = 1'b1;
                  other_tok.kind = KIND_QUOTE;
               end else begin
                  pstart_in = pos_ff;
                  pline_in  = line_in;
                  pcol_in   = col_in;
                  plen_in   = CNT_W'(1);
                  if (src_byte == "\"") begin
                     mode_in = MODE_STRING;
                  end else begin
                     chars_in   = {src_byte, 8'h00};
                     sign_in    = (src_byte == "+") || (src_byte == "-");
                     numeric_in = sign_in || is_digit || src_byte == ".";
                     dots_in    = (src_byte == ".") ? 2'd1 : 2'd0;
                     mode_in    = MODE_SYMBOL;
                  end
               end
            end
         end
      end
   end

   // order the tokens: pending symbol first
   always_comb begin
      push = '0;
      if (flush) begin
         push.tok0  = sym_tok;
         push.tok1  = other_tok;
         push.count = other_v ? 2'd2 : 2'd1;
      end else begin
         push.tok0  = other_tok;
         push.count = other_v ? 2'd1 : 2'd0;
      end
   end

   // hold lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         pos_ff     <= '0;
         line_ff    <= CNT_W'(1);
         col_ff     <= '0;
         pstart_ff  <= '0;
         pline_ff   <= CNT_W'(1);
         pcol_ff    <= '0;
         plen_ff    <= '0;
         chars_ff   <= '0;
         numeric_ff <= 1'b1;
         dots_ff    <= 2'd0;
         sign_ff    <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         col_ff     <= col_in;
         pstart_ff  <= pstart_in;
         pline_ff   <= pline_in;
         pcol_ff    <= pcol_in;
         plen_ff    <= plen_in;
         chars_ff   <= chars_in;
         numeric_ff <= numeric_in;
         dots_ff    <= dots_in;
         sign_ff    <= sign_in;
         done_ff    <= done_in;
      end
   end

endmodule

// File: design/stl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue: four-entry token queue
// Takes up to two tokens a cycle, hands out one; flags room for a full step.
// ----------------------------------------------------------------------------
module stl_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  stl_pkg::push_type           push,
   output logic                        room,
   output logic                        out_valid,
   input  logic                        out_ready,
   output stl_pkg::token_type          out_tok,
   output logic                        out_last
);
   import stl_pkg::*;

   typedef struct packed {
      logic      last;
      token_type tok;
   } entry_type;

   entry_type  mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_next;

   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_tok   = mem_ff[rd_ptr_ff].tok;
   assign out_last  = mem_ff[rd_ptr_ff].last;
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ptr_ff + 2'd1;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store tokens; the final one of a step carries last
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff].tok  <= push.tok0;
         mem_ff[wr_ptr_ff].last <= (push.count == 2'd1);
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next].tok  <= push.tok1;
         mem_ff[wr_next].last <= 1'b1;
      end
   end

endmodule

// File: design/scheme_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheme_token_lexer: streaming tokenizer for s-expression source text
// Input register, single-pass lexer step and a small token queue.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per transfer (req_tdata) with req_tuser
//   marking end of source. rsp_* carries one token per transfer; rsp_tlast
//   marks the final token caused by a given source byte.
//   A byte lands in the input register, is lexed from there once the queue
//   has room, and its tokens (zero, one or two) go into a four-entry queue
//   whose head drives rsp_*.
//   One byte is taken every cycle while the queue has room for two tokens,
//   so a stream giving at most one token per byte, with rsp_tready high,
//   runs at one byte a cycle; two-token bytes drain at one token a cycle.
//   Reset clears the counters (line 1, column 0) and empties the queue.
//   When rsp_tready is low the queue fills and req_tready drops once fewer
//   than two free entries remain; nothing is lost. After the end or
//   unclosed-string token further bytes are taken and ignored until reset.
// ----------------------------------------------------------------------------
module scheme_token_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   input  logic        req_tuser,   // [0] source_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] token_kind, [19:4] token_start,
                                    // [35:20] token_length, [51:36] token_line,
                                    // [67:52] token_column, [71:68] zero
   output logic        rsp_tlast    // last_of_item
);
   import stl_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       room;
   logic       step;
   push_type   push;
   token_type  out_tok;

   assign step       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || step;

   // hold the incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tuser;
      end
   end

   stl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .src_byte (in_byte_ff),
      .src_end  (in_end_ff),
      .push     (push)
   );

   stl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, out_tok};

endmodule

// File: bench/lexer_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_token_checker: token predictor and comparator for scheme_token_lexer
// Watches both stream channels. Every source byte transfer is run through an
// independent model of the lexer, and the tokens it yields are queued. Every
// token transfer is compared field by field with the oldest queued token.
// ----------------------------------------------------------------------------
module lexer_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   input  logic        req_tuser,   // [0] source_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // [3:0] kind, [19:4] start, [35:20] length,
                                    // [51:36] line, [67:52] column, [71:68] zero
   input  logic        rsp_tlast,   // last token of one source byte
   output int          fault_count,
   output int          tokens_outstanding
);
   import stl_pkg::*;

   localparam int REPORT_LIMIT = 10;

   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_TICK   = "'";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SEMI   = ";";
   localparam logic [7:0] CH_DOT    = ".";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_SYMBOL,
      SCAN_STRING,
      SCAN_COMMENT
   } scan_mode_type;

   typedef struct packed {
      logic      last;
      token_type tok;
   } lexed_token_type;

   // lexer state
   scan_mode_type    mode;
   logic [CNT_W-1:0] pos;
   logic [CNT_W-1:0] line_no;
   logic [CNT_W-1:0] col_no;
   logic [CNT_W-1:0] lex_start;
   logic [CNT_W-1:0] lex_line;
   logic [CNT_W-1:0] lex_col;
   logic [CNT_W-1:0] lex_len;
   logic [15:0]      lead_pair;
   logic             all_numeric;
   logic [1:0]       dot_count;
   logic             signed_lead;
   logic             source_closed;

   token_type       step_tokens[$];
   lexed_token_type expected_tokens[$];

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic ends_lexeme(input logic [7:0] c);
      return is_blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE ||
             c == CH_SEMI || c == CH_TICK;
   endfunction

   // decide what a finished bare lexeme is
   function automatic logic [KIND_W-1:0] lexeme_kind();
      if (lex_len == 1 && lead_pair[15:8] == CH_DOT)
         return KIND_DOT;
      if (lex_len == 2 && (lead_pair == "#t" || lead_pair == "#f"))
         return KIND_BOOL;
      if (all_numeric && dot_count <= 1 && !(signed_lead && lex_len == 1))
         return KIND_NUMBER;
      return KIND_SYMBOL;
   endfunction

   task automatic clear_state();
      mode          = SCAN_IDLE;
      pos           = '0;
      line_no       = CNT_W'(1);
      col_no        = '0;
      lex_start     = '0;
      lex_line      = CNT_W'(1);
      lex_col       = '0;
      lex_len       = '0;
      lead_pair     = '0;
      all_numeric   = 1'b1;
      dot_count     = '0;
      signed_lead   = 1'b0;
      source_closed = 1'b0;
   endtask

   task automatic add_token(input logic [KIND_W-1:0] kind, input logic [CNT_W-1:0] start,
                            input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] line,
                            input logic [CNT_W-1:0] col);
      token_type t;
      t.kind   = kind;
      t.start  = start;
      t.length = len;
      t.line   = line;
      t.column = col;
      step_tokens.insert(step_tokens.size(), t);
   endtask

   task automatic close_lexeme();
      add_token(lexeme_kind(), lex_start, lex_len, lex_line, lex_col);
      mode = SCAN_IDLE;
   endtask

   task automatic open_lexeme(input logic [CNT_W-1:0] at);
      lex_start = at;
      lex_line  = line_no;
      lex_col   = col_no;
      lex_len   = CNT_W'(1);
   endtask

   // advance the counters and the scan mode by one source character
   task automatic consume_char(input logic [7:0] ch);
      logic [CNT_W-1:0] at;
      at  = pos;
      pos = sat_inc(pos);
      if (ch == CH_LF) begin
         line_no = sat_inc(line_no);
         col_no  = '0;
      end else begin
         col_no = sat_inc(col_no);
      end

      if (mode == SCAN_COMMENT) begin
         if (ch == CH_LF)
            mode = SCAN_IDLE;
         return;
      end
      if (mode == SCAN_STRING) begin
         lex_len = sat_inc(lex_len);
         if (ch == CH_DQUOTE) begin
            add_token(KIND_STRING, lex_start, lex_len, lex_line, lex_col);
            mode = SCAN_IDLE;
         end
         return;
      end
      if (mode == SCAN_SYMBOL) begin
         if (!ends_lexeme(ch)) begin
            if (lex_len == 1)
               lead_pair[7:0] = ch;
            if (!is_digit(ch) && ch != CH_DOT)
               all_numeric = 1'b0;
            if (ch == CH_DOT && dot_count < 2)
               dot_count++;
            lex_len = sat_inc(lex_len);
            return;
         end
         // the delimiter is handled below as a fresh character
         close_lexeme();
      end

      if (is_blank(ch)) begin
         // skip
      end else if (ch == CH_SEMI) begin
         mode = SCAN_COMMENT;
      end else if (ch == CH_LPAREN) begin
         add_token(KIND_LPAREN, at, CNT_W'(1), line_no, col_no);
      end else if (ch == CH_RPAREN) begin
         add_token(KIND_RPAREN, at, CNT_W'(1), line_no, col_no);
      end else if (ch == CH_TICK) begin
         add_token(KIND_QUOTE, at, CNT_W'(1), line_no, col_no);
      end else if (ch == CH_DQUOTE) begin
         open_lexeme(at);
         mode = SCAN_STRING;
      end else begin
         open_lexeme(at);
         lead_pair   = {ch, 8'h00};
         signed_lead = (ch == CH_PLUS || ch == CH_MINUS);
         all_numeric = signed_lead || is_digit(ch) || ch == CH_DOT;
         dot_count   = (ch == CH_DOT) ? 2'd1 : 2'd0;
         mode        = SCAN_SYMBOL;
      end
   endtask

   // predict the tokens of one source transfer and queue them
   task automatic lex_byte(input logic [7:0] ch, input logic eos);
      lexed_token_type e;
      step_tokens.delete();
      if (!source_closed) begin
         if (eos) begin
            if (mode == SCAN_STRING) begin
               add_token(KIND_ERROR, lex_start, lex_len, lex_line, lex_col);
            end else begin
               if (mode == SCAN_SYMBOL)
                  close_lexeme();
               add_token(KIND_END, pos, '0, line_no, col_no);
            end
            mode          = SCAN_IDLE;
            source_closed = 1'b1;
         end else begin
            consume_char(ch);
         end
      end
      foreach (step_tokens[i]) begin
         e.tok  = step_tokens[i];
         e.last = (i == step_tokens.size() - 1);
         expected_tokens.insert(expected_tokens.size(), e);
      end
   endtask

   // compare one token transfer against the oldest prediction
   task automatic check_token(input token_type got, input logic got_last);
      lexed_token_type want;
      if (expected_tokens.size() == 0) begin
         if (fault_count < REPORT_LIMIT) begin
            $display("%0t: unexpected token", $realtime);
            $display("   actual   kind %0d start %0d length %0d line %0d col %0d last %0b",
                     got.kind, got.start, got.length, got.line, got.column, got_last);
         end
         fault_count++;
         return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.tok.kind || got.start !== want.tok.start ||
          got.length !== want.tok.length || got.line !== want.tok.line ||
          got.column !== want.tok.column || got_last !== want.last) begin
         if (fault_count < REPORT_LIMIT) begin
            $display("%0t: token mismatch", $realtime);
            $display("   expected kind %0d start %0d length %0d line %0d col %0d last %0b",
                     want.tok.kind, want.tok.start, want.tok.length, want.tok.line,
                     want.tok.column, want.last);
            $display("   actual   kind %0d start %0d length %0d line %0d col %0d last %0b",
                     got.kind, got.start, got.length, got.line, got.column, got_last);
         end
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready)
            lex_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready)
            check_token(rsp_tdata[67:0], rsp_tlast);
      end
      tokens_outstanding <= expected_tokens.size();
   end

endmodule

// File: bench/tb_scheme_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scheme_token_lexer: stimulus and verdict for the s-expression lexer
// Feeds a directed opening, a few hundred bytes of randomly built lexemes
// and noise, and finally one of the end-of-source cases followed by ignored
// bytes. Both channels stall at random; the checker instance does all the
// comparing.
// ----------------------------------------------------------------------------
module tb_scheme_token_lexer;
   import stl_pkg::*;

   localparam int RANDOM_ITEMS = 340;
   localparam int IDLE_PCT     = 27;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] source_byte
   logic        req_tuser;    // [0] source_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [3:0] kind, [19:4] start, [35:20] length,
                              // [51:36] line, [67:52] column, [71:68] zero
   logic        rsp_tlast;    // last token of one source byte

   int fault_count;
   int tokens_outstanding;
   int items_sent;
   int random_base;
   bit steady;

   scheme_token_lexer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   lexer_token_checker token_check (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tlast          (rsp_tlast),
      .fault_count        (fault_count),
      .tokens_outstanding (tokens_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hold one byte on the request channel until it is taken
   task automatic send_item(input logic [7:0] ch, input logic eos);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   // any byte that keeps a bare lexeme going
   function automatic logic [7:0] symbol_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == "(" ||
             c == ")" || c == "\"" || c == ";" || c == "'");
      return c;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(3))
         0: return " ";
         1: return 8'h09;
         2: return 8'h0D;
         default: return 8'h0A;
      endcase
   endfunction

   // one random lexeme, whitespace run, comment or burst of noise
   task automatic send_random_word();
      int n;
      logic [7:0] c;
      case ($urandom_range(11))
         0: send_text("(");
         1: send_text(")");
         2: send_text("'");
         3: begin
            send_text("\"");
            n = $urandom_range(6);
            repeat (n) begin
               do c = 8'($urandom_range(255)); while (c == "\"");
               send_item(c, 1'b0);
            end
            send_text("\"");
         end
         4: begin
            if ($urandom_range(1))
               send_item($urandom_range(1) ? "+" : "-", 1'b0);
            n = $urandom_range(1, 4);
            repeat (n)
               send_item(($urandom_range(4) == 0) ? "." : 8'h30 + 8'($urandom_range(9)),
                         1'b0);
         end
         5: begin
            send_text("#");
            case ($urandom_range(4))
               0, 1: send_text("t");
               2, 3: send_text("f");
               default: send_item(symbol_byte(), 1'b0);
            endcase
            if ($urandom_range(3) == 0)
               send_item(symbol_byte(), 1'b0);
         end
         6: begin
            case ($urandom_range(3))
               0: send_text(".");
               1: send_text("+");
               2: send_text("-");
               default: send_text("..");
            endcase
         end
         7: begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(symbol_byte(), 1'b0);
         end
         8: begin
            send_text(";");
            n = $urandom_range(5);
            repeat (n) begin
               do c = 8'($urandom_range(255)); while (c == 8'h0A);
               send_item(c, 1'b0);
            end
            send_item(8'h0A, 1'b0);
         end
         9, 10: begin
            n = $urandom_range(1, 2);
            repeat (n) send_item(blank_byte(), 1'b0);
         end
         default: begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(8'($urandom_range(255)), 1'b0);
         end
      endcase
      // leave some lexemes touching so delimiters get tested
      if ($urandom_range(9) < 6)
         send_item(blank_byte(), 1'b0);
   endtask

   // stall the token channel at random, except in the steady stretch
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // end the run when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      steady      = 1'b0;
      items_sent  = 0;
      random_base = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed opening: all kinds but end and error, sign alone, dot
      // alone, two dots, ';' inside a string, NUL and 0xFF as symbol characters
      send_text("(#t #f\t-1.2)+ .\r1..\";\"'");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text(";c\n");

      // random lexemes, with a steady stretch in the middle
      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         steady = (items_sent - random_base >= 150) && (items_sent - random_base < 250);
         send_random_word();
      end
      steady = 1'b0;

      // close the source in one of its possible modes
      case ($urandom_range(3))
         0: send_text("ab");
         1: send_text("\"ab");
         2: send_text(";ab");
         default: send_text(" ");
      endcase
      send_item(8'($urandom_range(255)), 1'b1);

      // bytes after the end are dropped
      repeat (4) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (tokens_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && tokens_outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
design/stl_pkg.sv
design/stl_core.sv
design/stl_queue.sv
design/scheme_token_lexer.sv
bench/lexer_token_checker.sv
bench/tb_scheme_token_lexer.sv
